@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FPRC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fprc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FPRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fprc assertion failed");

`endif

@@ hdl/fprc_pkg.sv @@
// Shared types, constants and the CRC-16/MODBUS byte update for the frame receiver.
// No dependencies.
package fprc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // register reset values
    localparam logic [7:0] LEAD_RST      = 8'h01;
    localparam logic [7:0] ADDR_LIM_RST  = 8'h0A;
    localparam logic [7:0] SYNC_RST      = 8'hAA;
    localparam logic [7:0] TAIL_RST      = 8'h55;
    localparam logic [7:0] MAX_LEN_RST   = 8'd100;
    localparam logic [7:0] MIN_LEN       = 8'd7;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_LEAD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDR_LIM = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN  = 3'd4;

    // status codes on the tail byte
    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_TAIL = 2'd2;

    localparam int unsigned RES_SLOTS = 4;
    localparam int unsigned COUNT_W   = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_start;
        logic       frame_end;
        logic [1:0] status;
    } fprc_result_t;

    // results of one processed byte, handed to the output buffer
    typedef struct packed {
        logic                            load;
        logic [COUNT_W-1:0]              count;
        fprc_result_t [RES_SLOTS-1:0]    item;
    } fprc_batch_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hdl/fprc_frame_ctrl.sv @@
// Input register, configuration registers and the per-byte frame logic.
// Depends on fprc_pkg.
module fprc_frame_ctrl (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_in_byte,
    input  logic                                  cfg_wr_en,
    input  logic [fprc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [7:0]                            cfg_wdata,
    input  logic                                  can_load,
    output fprc_pkg::fprc_batch_t                 batch
);
    import fprc_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;

    logic [7:0]  lead_reg, addr_lim_reg, sync_reg, tail_reg, max_len_reg;

    logic [23:0] window_reg, window_next;
    logic [1:0]  fill_reg, fill_next;
    logic        collecting_reg, collecting_next;
    logic [7:0]  index_reg, index_next;
    logic [7:0]  total_reg, total_next;
    logic [15:0] crc_reg, crc_next;
    logic        failed_reg, failed_next;

    logic        step;
    logic        hdr_match;
    logic [7:0]  w2, w1, w0, b;
    logic [8:0]  idx_p3, idx_p2, tot9;
    logic [15:0] hdr_crc, crc_upd;

    assign step    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || can_load;

    assign b  = in_byte_reg;
    assign w2 = window_reg[23:16];
    assign w1 = window_reg[15:8];
    assign w0 = window_reg[7:0];

    assign hdr_match = (fill_reg == 2'd3) && (w2 == lead_reg) && (w1 < addr_lim_reg) &&
                       (w0 == sync_reg) && (b >= MIN_LEN) && (b <= max_len_reg);

    assign hdr_crc = crc16_byte(crc16_byte(CRC_INIT, w0), b);
    assign crc_upd = crc16_byte(crc_reg, b);

    assign idx_p3 = {1'b0, index_reg} + 9'd3;
    assign idx_p2 = {1'b0, index_reg} + 9'd2;
    assign tot9   = {1'b0, total_reg};

    always_comb begin
        in_valid_next   = in_valid_reg;
        window_next     = window_reg;
        fill_next       = fill_reg;
        collecting_next = collecting_reg;
        index_next      = index_reg;
        total_next      = total_reg;
        crc_next        = crc_reg;
        failed_next     = failed_reg;
        batch           = '0;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        if (step) begin
            batch.load = 1'b1;
            if (!collecting_reg) begin
                if (hdr_match) begin
                    batch.count                = COUNT_W'(4);
                    batch.item[0].out_byte     = w2;
                    batch.item[0].frame_start  = 1'b1;
                    batch.item[1].out_byte     = w1;
                    batch.item[2].out_byte     = w0;
                    batch.item[3].out_byte     = b;
                    collecting_next = 1'b1;
                    total_next      = b;
                    index_next      = 8'd4;
                    crc_next        = hdr_crc;
                    failed_next     = 1'b0;
                    window_next     = '0;
                    fill_next       = '0;
                end else begin
                    window_next = {window_reg[15:0], b};
                    if (fill_reg != 2'd3) begin
                        fill_next = fill_reg + 2'd1;
                    end
                end
            end else begin
                batch.count            = COUNT_W'(1);
                batch.item[0].out_byte = b;
                index_next             = index_reg + 8'd1;
                priority if (idx_p3 < tot9) begin
                    crc_next = crc_upd;
                end else if (idx_p3 == tot9) begin
                    if (b != crc_reg[7:0]) failed_next = 1'b1;
                end else if (idx_p2 == tot9) begin
                    if (b != crc_reg[15:8]) failed_next = 1'b1;
                end else begin
                    // tail byte: report and return to hunting
                    batch.item[0].frame_end = 1'b1;
                    batch.item[0].status    = failed_reg ? STATUS_CRC_ERR :
                                              ((b != tail_reg) ? STATUS_BAD_TAIL : STATUS_GOOD);
                    collecting_next = 1'b0;
                    window_next     = '0;
                    fill_next       = '0;
                    index_next      = '0;
                    total_next      = '0;
                    crc_next        = CRC_INIT;
                    failed_next     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            window_reg     <= '0;
            fill_reg       <= '0;
            collecting_reg <= 1'b0;
            index_reg      <= '0;
            total_reg      <= '0;
            crc_reg        <= CRC_INIT;
            failed_reg     <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            window_reg     <= window_next;
            fill_reg       <= fill_next;
            collecting_reg <= collecting_next;
            index_reg      <= index_next;
            total_reg      <= total_next;
            crc_reg        <= crc_next;
            failed_reg     <= failed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg     <= LEAD_RST;
            addr_lim_reg <= ADDR_LIM_RST;
            sync_reg     <= SYNC_RST;
            tail_reg     <= TAIL_RST;
            max_len_reg  <= MAX_LEN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LEAD:     lead_reg     <= cfg_wdata;
                REG_ADDR_LIM: addr_lim_reg <= cfg_wdata;
                REG_SYNC:     sync_reg     <= cfg_wdata;
                REG_TAIL:     tail_reg     <= cfg_wdata;
                REG_MAX_LEN:  max_len_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/fprc_out_buf.sv @@
// Result register: holds up to four results of one byte and hands them out in order.
// Depends on fprc_pkg.
module fprc_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fprc_pkg::fprc_batch_t  batch,
    output logic                   can_load,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_frame_start,
    output logic                   m_frame_end,
    output logic [1:0]             m_status
);
    import fprc_pkg::*;

    fprc_result_t [RES_SLOTS-1:0] slot_reg, slot_next;
    logic [COUNT_W-1:0]           cnt_reg, cnt_next;

    assign m_valid  = (cnt_reg != '0);
    assign can_load = (cnt_reg == '0) || ((cnt_reg == COUNT_W'(1)) && m_ready);

    assign m_out_byte    = slot_reg[0].out_byte;
    assign m_frame_start = slot_reg[0].frame_start;
    assign m_frame_end   = slot_reg[0].frame_end;
    assign m_status      = slot_reg[0].status;

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (batch.load) begin
            slot_next = batch.item;
            cnt_next  = batch.count;
        end else if (m_valid && m_ready) begin
            for (int i = 0; i < RES_SLOTS - 1; i++) begin
                slot_next[i] = slot_reg[i+1];
            end
            cnt_next = cnt_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hdl/framed_packet_receiver_crc16.sv @@
// Order: an accepted byte is held in the input register and processed when the result
// register can load; its results are registered there and shown from it.
// Throughput: one byte per cycle while m_ready holds; a byte completing a header yields
// four results, output one per cycle while m_ready is high; input stalls until the last goes.
// Reset (aresetn low, synchronous): registers to defaults, hunting for a header, no results.
module framed_packet_receiver_crc16 (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input byte stream
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_in_byte,
    // frame byte stream
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_out_byte,
    output logic                              m_frame_start,
    output logic                              m_frame_end,
    output logic [1:0]                        m_status,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [fprc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                        cfg_wdata
);
    import fprc_pkg::*;

    // One transaction per input byte. The control stage registers the byte, then in a
    // single pass it either shifts the byte into the three-byte hunting window or, on a
    // full header match with an acceptable length, releases all four header bytes at once.
    // Inside a frame every byte passes straight through; the CRC covers sync to last
    // payload byte, the two CRC bytes are compared, and the tail carries the status.
    fprc_batch_t batch;
    logic        can_load;

    fprc_frame_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .can_load  (can_load),
        .batch     (batch)
    );

    // Result register: reloads as its last result leaves, so a byte per cycle flows through
    // without bubbles while single results are produced and m_ready is high.
    fprc_out_buf u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .batch         (batch),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_start (m_frame_start),
        .m_frame_end   (m_frame_end),
        .m_status      (m_status)
    );

endmodule

@@ hdl/fprc_checker.sv @@
// Port-level checks on the frame receiver, bound to the top level.
// Depends on fprc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fprc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_frame_start,
    input logic        m_frame_end,
    input logic [1:0]  m_status
);
    import fprc_pkg::*;

    // a frame is at least seven bytes, so start and end never share a byte
    `FPRC_ASSERT_NOW(a_start_end_apart, aclk, aresetn, m_valid, !(m_frame_start && m_frame_end))

    // status only means something on the tail byte
    `FPRC_ASSERT_NOW(a_status_on_tail, aclk, aresetn, m_valid && !m_frame_end, m_status == '0)

    `FPRC_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid, m_status <= STATUS_BAD_TAIL)

    // stalled result stays valid with its byte and end flag held
    `FPRC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_frame_end))

endmodule

bind framed_packet_receiver_crc16 fprc_checker u_fprc_checker (.*);
